@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the window peak counter.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under an active-low reset.
`define WPC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication under an active-low reset.
`define WPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define WPC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define WPC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/wpc_pkg.sv @@
// Package of the window peak counter: widths, defaults and shared types.
// No dependencies.
package wpc_pkg;

    localparam int DEF_MAX_WINDOW = 1024;
    localparam int DEF_MAX_LENGTH = 65536;
    localparam int CFG_W          = 11;
    localparam int SAMPLE_W       = 32;
    localparam int PARTS_W        = 10;
    localparam int START_W        = 17;
    localparam int MIN_WINDOW     = 3;
    localparam logic [CFG_W-1:0] WLEN_RESET = CFG_W'(MIN_WINDOW);

    // Control word handed from the sequencer to the flag chain.
    typedef struct packed {
        logic shift;   // advance every cell by one place
        logic clear;   // drop all flags (end of sequence)
        logic flag;    // peak flag entering cell 0
    } chain_ctrl_t;

endpackage

@@ hdl/wpc_cell.sv @@
// One cell of the peak flag chain: holds one flag, passes it on to its neighbor.
// Depends on wpc_pkg.
module wpc_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wpc_pkg::chain_ctrl_t ctrl,
    input  logic                flag_in,
    input  logic [IDX_W-1:0]    tap_idx,
    output logic                flag_out,
    output logic                tap
);

    logic flag_reg;
    logic flag_next;

    always_comb
    begin
        flag_next = flag_reg;
        if (ctrl.clear)
        begin
            flag_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            flag_next = flag_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign flag_out = flag_reg;
    // Drive the tap only when this cell is the one leaving the window.
    assign tap      = flag_reg & (tap_idx == IDX_W'(IDX));

endmodule

@@ hdl/wpc_chain.sv @@
// Row of flag cells forming the peak history, plus the selected tap.
// Depends on wpc_pkg and wpc_cell.
module wpc_chain #(
    parameter int NCELL = 1022,
    parameter int IDX_W = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wpc_pkg::chain_ctrl_t ctrl,
    input  logic [IDX_W-1:0]     tap_idx,
    output logic                 removed
);

    logic [NCELL-1:0] flags;
    logic [NCELL-1:0] taps;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic flag_in;
        if (i == 0)
        begin : g_head
            assign flag_in = ctrl.flag;
        end
        else
        begin : g_body
            assign flag_in = flags[i-1];
        end

        wpc_cell #(
            .IDX   (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .flag_in  (flag_in),
            .tap_idx  (tap_idx),
            .flag_out (flags[i]),
            .tap      (taps[i])
        );
    end

    assign removed = |taps;

endmodule

@@ hdl/window_peak_count_max_core.sv @@
// Top level of the sliding-window peak counter.
// Depends on wpc_pkg, wpc_chain (and wpc_cell), assert_macros.svh.
//
// Usage:
//   Input words (sample, last_sample) enter on in_valid / in_stall, one per
//   cycle. A sample is a peak when strictly greater than both neighbors; the
//   peak flags run through a chain of one-bit cells, and the window count is
//   kept as a running sum (add the new flag, drop the flag leaving the window
//   interior, picked from the chain by a decoded tap).
//   The word carrying last_sample = 1 produces one result word on out_valid /
//   out_stall: parts, window_start, bad_length. Other words produce none.
//   The result is registered into the result queue when the last word is taken.
//   Throughput: one word per cycle while in_stall is low, as the running
//   count and the best-window compare are updated with every taken word.
//   The result side has a two-word queue; in_stall rises only while both
//   entries are held by a stalled receiver.
//   window_length is written through cfg_valid / cfg_ready (always ready);
//   it is clamped to 3..KMAX (MAX_WINDOW, at most 2047) and applies from the next sample.
//   Reset (rst_n low, asynchronous) clears the sequence, the queue and sets
//   window_length to 3. No clearing pass is needed after reset.
module window_peak_count_max_core #(
    parameter int MAX_WINDOW = wpc_pkg::DEF_MAX_WINDOW,
    parameter int MAX_LENGTH = wpc_pkg::DEF_MAX_LENGTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [wpc_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_sample,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [wpc_pkg::PARTS_W-1:0]         parts,
    output logic [wpc_pkg::START_W-1:0]         window_start,
    output logic                                bad_length,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wpc_pkg::CFG_W-1:0]           window_length
);

`include "assert_macros.svh"

    localparam int CFG_W   = wpc_pkg::CFG_W;
    localparam int PARTS_W = wpc_pkg::PARTS_W;
    localparam int START_W = wpc_pkg::START_W;
    // Largest window the register can actually select.
    localparam int KMAX    = (MAX_WINDOW < (2**CFG_W - 1)) ? MAX_WINDOW : (2**CFG_W - 1);
    localparam int NCELL   = KMAX - 2;
    localparam int IDX_W   = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int IW      = $clog2(MAX_LENGTH + 1);
    localparam int CW      = ((IW > CFG_W) ? IW : CFG_W) + 1;
    localparam int SW      = ((IW + 1) > START_W) ? (IW + 1) : START_W;

    typedef struct packed {
        logic [PARTS_W-1:0] parts;
        logic [START_W-1:0] start;
        logic               bad;
    } res_t;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] wlen_reg;
    logic [CFG_W-1:0] k_eff;
    logic [IDX_W-1:0] tap_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= wpc_pkg::WLEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wlen_reg <= window_length;
        end
    end

    // Clamp to the legal window range.
    always_comb
    begin
        k_eff = wlen_reg;
        if (wlen_reg < CFG_W'(wpc_pkg::MIN_WINDOW))
        begin
            k_eff = CFG_W'(wpc_pkg::MIN_WINDOW);
        end
        else if (wlen_reg > CFG_W'(KMAX))
        begin
            k_eff = CFG_W'(KMAX);
        end
    end

    // Flag leaving the interior: held (k-3) places down the chain before the shift.
    assign tap_idx = IDX_W'(k_eff - CFG_W'(wpc_pkg::MIN_WINDOW));

    // ---------------------------------------------------------------
    // Sequence state
    // ---------------------------------------------------------------
    logic signed [wpc_pkg::SAMPLE_W-1:0] prev_reg,  prev2_reg;
    logic [IW-1:0]                       idx_reg;
    logic [PARTS_W-1:0]                  run_reg,   best_reg;
    logic [IW-1:0]                       bstart_reg;
    logic                                too_long_reg;

    logic               accept;
    logic               active;
    logic               peak;
    logic               shift;
    logic               removed;
    logic [PARTS_W-1:0] run_upd;
    logic [CW-1:0]      j1;
    logic [CW-1:0]      kc;
    logic [CW-1:0]      n_cw;
    logic               take;
    logic [IW-1:0]      l_idx;
    logic [PARTS_W-1:0] best_fin;
    logic [IW-1:0]      bstart_fin;
    logic               bad;
    logic [SW-1:0]      ws_wide;
    res_t               res_new;
    wpc_pkg::chain_ctrl_t chain_ctrl;

    assign accept = in_valid && !in_stall;
    // Stop updating once the maximum length has been reached.
    assign active = (idx_reg != IW'(MAX_LENGTH));
    assign peak   = (idx_reg >= IW'(2)) && (prev2_reg < prev_reg) && (prev_reg > sample);
    assign shift  = accept && active && (idx_reg != '0);

    assign run_upd = run_reg + PARTS_W'(peak) - PARTS_W'(removed);
    assign j1      = CW'(idx_reg) + CW'(1);
    assign kc      = CW'(k_eff);
    assign l_idx   = IW'(j1 - kc);
    assign take    = (j1 >= kc) && ((l_idx == '0) || (run_upd > best_reg));

    assign best_fin   = (shift && take) ? run_upd : best_reg;
    assign bstart_fin = (shift && take) ? l_idx : bstart_reg;
    assign n_cw       = CW'(idx_reg) + (active ? CW'(1) : CW'(0));
    assign bad        = too_long_reg || !active || (n_cw < kc);
    assign ws_wide    = SW'(bstart_fin) + SW'(1);

    always_comb
    begin
        res_new.parts = best_fin + PARTS_W'(1);
        res_new.start = ws_wide[START_W-1:0];
        res_new.bad   = 1'b0;
        if (bad)
        begin
            res_new.parts = '0;
            res_new.start = '0;
            res_new.bad   = 1'b1;
        end
    end

    assign chain_ctrl.shift = shift;
    assign chain_ctrl.clear = accept && last_sample;
    assign chain_ctrl.flag  = peak;

    wpc_chain #(
        .NCELL (NCELL),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (chain_ctrl),
        .tap_idx (tap_idx),
        .removed (removed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            prev2_reg    <= '0;
            idx_reg      <= '0;
            run_reg      <= '0;
            best_reg     <= '0;
            bstart_reg   <= '0;
            too_long_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_sample)
            begin
                // Sequence done: drop everything for the next one.
                prev_reg     <= '0;
                prev2_reg    <= '0;
                idx_reg      <= '0;
                run_reg      <= '0;
                best_reg     <= '0;
                bstart_reg   <= '0;
                too_long_reg <= 1'b0;
            end
            else if (!active)
            begin
                too_long_reg <= 1'b1;
            end
            else
            begin
                prev2_reg <= prev_reg;
                prev_reg  <= sample;
                idx_reg   <= idx_reg + IW'(1);
                if (shift)
                begin
                    run_reg    <= run_upd;
                    best_reg   <= best_fin;
                    bstart_reg <= bstart_fin;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result queue: head drives the port, tail absorbs one stalled word
    // ---------------------------------------------------------------
    logic [1:0] cnt_reg, cnt_next;
    res_t       head_reg, head_next;
    res_t       tail_reg, tail_next;
    logic       push, pop;

    assign push = accept && last_sample;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_next = tail_reg;
                tail_next = res_new;
            end
            else
            begin
                head_next = res_new;
            end
        end
        else if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_next = res_new;
            end
            else
            begin
                tail_next = res_new;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign in_stall     = (cnt_reg == 2'd2);
    assign out_valid    = (cnt_reg != 2'd0);
    assign parts        = head_reg.parts;
    assign window_start = head_reg.start;
    assign bad_length   = head_reg.bad;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `WPC_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && bad_length, parts == '0 && window_start == '0)
    `WPC_ASSERT_NEXT(a_last_result, clk, rst_n, accept && last_sample, out_valid)
    `WPC_ASSERT_NEXT(a_last_clear, clk, rst_n, accept && last_sample, idx_reg == '0 && run_reg == '0 && !too_long_reg)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of window_peak_count_max_core.
// Depends on wpc_pkg and the RTL below the top level; reads no files.
`timescale 1ns / 100ps

module tb_top;

    localparam int SAMPLE_W   = wpc_pkg::SAMPLE_W;
    localparam int PARTS_W    = wpc_pkg::PARTS_W;
    localparam int START_W    = wpc_pkg::START_W;
    localparam int CFG_W      = wpc_pkg::CFG_W;
    localparam int MIN_WINDOW = wpc_pkg::MIN_WINDOW;
    localparam logic [CFG_W-1:0] WLEN_RESET = wpc_pkg::WLEN_RESET;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 850;
    localparam int MAX_WIN      = wpc_pkg::DEF_MAX_WINDOW;
    localparam int MAX_LEN      = wpc_pkg::DEF_MAX_LENGTH;

    localparam logic signed [SAMPLE_W-1:0] SMIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] SMAX = 32'sh7FFF_FFFF;

    typedef enum logic { ROW_SAMPLE, ROW_WLEN } row_kind_t;

    // One row of the directed table: a sample word, or a window length write.
    // Where typed is set the expected result is given here, else predicted.
    typedef struct packed {
        row_kind_t                   kind;
        logic signed [SAMPLE_W-1:0]  value;
        logic                        last;
        logic                        typed;
        logic [PARTS_W-1:0]          parts;
        logic [START_W-1:0]          start;
        logic                        bad;
    } stim_row_t;

    typedef struct packed {
        logic [PARTS_W-1:0] parts;
        logic [START_W-1:0] start;
        logic               bad;
    } window_result_t;

    localparam int DIR_ROWS = 28;

    stim_row_t dir_rows [DIR_ROWS] = '{
        // single word sequence: too short for the reset window of 3
        '{ROW_SAMPLE, 32'sd0, 1'b1, 1'b1, 10'd0, 17'd0, 1'b1},
        // extremes: min, max, min gives one peak in the first window
        '{ROW_SAMPLE, SMIN,   1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, SMAX,   1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, SMIN,   1'b1, 1'b1, 10'd2, 17'd1, 1'b0},
        // two words: short
        '{ROW_SAMPLE, 32'sd7, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, -32'sd8, 1'b1, 1'b1, 10'd0, 17'd0, 1'b1},
        // window length 0 clamps to 3; two peaks, tie keeps the leftmost
        '{ROW_WLEN,   32'sd0, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd1, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd3, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd2, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd4, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd1, 1'b1, 1'b0, 10'd0, 17'd0, 1'b0},
        // all ones clamps to the maximum window: three words are short
        '{ROW_WLEN,   32'sd2047, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd1, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd2, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd1, 1'b1, 1'b1, 10'd0, 17'd0, 1'b1},
        // change the window in the middle of a sequence (1 clamps to 3)
        '{ROW_WLEN,   32'sd4, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd0, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd9, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd0, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_WLEN,   32'sd1, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd9, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd0, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd5, 1'b1, 1'b0, 10'd0, 17'd0, 1'b0},
        // equal neighbors are no peak
        '{ROW_WLEN,   32'sd3, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd1, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd3, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0},
        '{ROW_SAMPLE, 32'sd3, 1'b0, 1'b0, 10'd0, 17'd0, 1'b0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [SAMPLE_W-1:0]   sample;
    logic                         last_sample;
    logic                         out_valid;
    logic                         out_stall;
    logic [PARTS_W-1:0]           parts;
    logic [START_W-1:0]           window_start;
    logic                         bad_length;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_W-1:0]             window_length;

    // Shadow of the block: register, last two samples, peak flag ring
    logic [CFG_W-1:0]             wlen_reg;
    logic signed [SAMPLE_W-1:0]   prev_s;
    logic signed [SAMPLE_W-1:0]   prev2_s;
    int unsigned                  seq_len;
    bit                           flag_ring [MAX_WIN];
    int unsigned                  ring_head;
    logic [PARTS_W-1:0]           run_cnt;
    logic [PARTS_W-1:0]           best_cnt;
    int unsigned                  best_at;
    bit                           overflowed;

    window_result_t               pending_windows [$];

    int                           mismatch_cnt;
    int                           results_seen;
    int                           words_sent;
    int                           cfg_writes;
    int                           cycle_cnt;
    int                           rx_wait;
    bit                           rx_quiet;
    bit                           tx_quiet;

    window_peak_count_max_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parts        (parts),
        .window_start (window_start),
        .bad_length   (bad_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_length(window_length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drop every piece of sequence state; the window length register stays.
    function automatic void clear_sequence();
        prev_s     = '0;
        prev2_s    = '0;
        seq_len    = 0;
        for (int i = 0; i < MAX_WIN; i++)
            flag_ring[i] = 1'b0;
        ring_head  = 0;
        run_cnt    = '0;
        best_cnt   = '0;
        best_at    = 0;
        overflowed = 1'b0;
    endfunction

    // Advance the shadow by one sample word; return 1 when the word closes a
    // sequence, with the best window (or the length error) in res.
    function automatic bit predict_peak_window(input logic signed [SAMPLE_W-1:0] s,
                                               input bit last,
                                               output window_result_t res);
        int unsigned k;
        int unsigned lpos;
        bit          pk;
        k   = wlen_reg;
        res = '0;
        if (k < MIN_WINDOW)
            k = MIN_WINDOW;
        if (k > MAX_WIN)
            k = MAX_WIN;
        if (seq_len >= MAX_LEN)
            overflowed = 1'b1;
        else
        begin
            if (seq_len >= 1)
            begin
                // the flag of the middle word is known once its right neighbor arrives
                pk = (seq_len >= 2) && (prev2_s < prev_s) && (prev_s > s);
                ring_head = (ring_head + MAX_WIN - 1) % MAX_WIN;
                flag_ring[ring_head] = pk;
                run_cnt = run_cnt + PARTS_W'(pk)
                          - PARTS_W'(flag_ring[(ring_head + k - 2) % MAX_WIN]);
                if (seq_len + 1 >= k)
                begin
                    lpos = seq_len + 1 - k;
                    if (lpos == 0 || run_cnt > best_cnt)
                    begin
                        best_cnt = run_cnt;
                        best_at  = lpos;
                    end
                end
            end
            prev2_s = prev_s;
            prev_s  = s;
            seq_len = seq_len + 1;
        end
        if (!last)
            return 1'b0;
        if (overflowed || seq_len < k)
            res.bad = 1'b1;
        else
        begin
            res.parts = best_cnt + PARTS_W'(1);
            res.start = START_W'(best_at + 1);
        end
        clear_sequence();
        return 1'b1;
    endfunction

    // Small values half the time so that peaks and equal neighbors are common,
    // with full-range words and values hugging both extremes mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return $signed(SAMPLE_W'($urandom_range(0, 8))) - 32'sd4;
            4, 5:       return $urandom;
            6:          return SMIN + SAMPLE_W'($urandom_range(0, 2));
            default:    return SMAX - SAMPLE_W'($urandom_range(0, 2));
        endcase
    endfunction

    // Hold the sender off until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_windows.size() != 0)
            @(posedge clk);
    endtask

    // Write the window length while the block is idle.
    task automatic write_wlen(input logic [CFG_W-1:0] v);
        drain();
        repeat (3) @(posedge clk);
        cfg_valid     <= 1'b1;
        window_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        wlen_reg   = v;
        cfg_writes++;
    endtask

    // Present one sample word after a random gap (none while tx_quiet is set) and hold it until taken.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input bit last,
                             input bit typed, input window_result_t typed_res);
        int             gap;
        window_result_t res;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s;
        last_sample <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_peak_window(s, last, res))
            pending_windows.push_back(typed ? typed_res : res);
        words_sent++;
    endtask

    // Result side: stall at random after each taken word unless rx_quiet is set, check every taken
    // word against the oldest expectation.
    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_windows.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected result parts=%0d start=%0d bad=%0b",
                             $realtime, parts, window_start, bad_length);
            end
            else
            begin
                want = pending_windows.pop_front();
                if (parts !== want.parts || window_start !== want.start
                    || bad_length !== want.bad)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 $realtime, want.parts, want.start, want.bad,
                                 parts, window_start, bad_length);
                end
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 10);
        end
        else if (rx_wait != 0)
            rx_wait--;
        out_stall <= (rx_wait != 0);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int             k_eff;
        int             seq_words;
        int             nseq;
        int             rand_words;
        logic [CFG_W-1:0] wcfg;
        window_result_t typed_res;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample        = '0;
        last_sample   = 1'b0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        window_length = WLEN_RESET;
        wlen_reg      = WLEN_RESET;
        mismatch_cnt  = 0;
        results_seen  = 0;
        words_sent    = 0;
        cfg_writes    = 0;
        cycle_cnt     = 0;
        rx_wait       = 0;
        rx_quiet      = 1'b0;
        tx_quiet      = 1'b0;
        rand_words    = 0;
        clear_sequence();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, clamps, short and mid-sequence changes
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_WLEN)
                write_wlen(CFG_W'(dir_rows[r].value));
            else
            begin
                typed_res = '{dir_rows[r].parts, dir_rows[r].start, dir_rows[r].bad};
                send_word(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                          typed_res);
            end
        end
        // close the equal-neighbor sequence: no peak, first window wins
        send_word(32'sd1, 1'b1, 1'b1, '{PARTS_W'(1), START_W'(1), 1'b0});

        // Random phases: a new window length, then a batch of sequences
        while (rand_words < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: wcfg = CFG_W'($urandom_range(3, 8));
                6, 7:             wcfg = CFG_W'($urandom_range(9, 40));
                8:                wcfg = CFG_W'($urandom_range(0, 2));
                default:          wcfg = CFG_W'($urandom_range(1000, 2047));
            endcase
            write_wlen(wcfg);
            k_eff = (wcfg < MIN_WINDOW) ? MIN_WINDOW : (wcfg > MAX_WIN) ? MAX_WIN : wcfg;
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            nseq = $urandom_range(3, 10);
            for (int q = 0; q < nseq && rand_words < RANDOM_WORDS; q++)
            begin
                // some sequences (all of them for windows of 1000 or more) are cut short of a full window
                if (k_eff >= 1000 || $urandom_range(0, 7) == 0)
                    seq_words = $urandom_range(1, (k_eff > 13) ? 12 : k_eff - 1);
                else
                    seq_words = k_eff + $urandom_range(0, (k_eff * 2 > 24) ? 24 : k_eff * 2);
                for (int i = 0; i < seq_words; i++)
                begin
                    if ($urandom_range(0, 39) == 0)
                        drain();
                    send_word(pick_sample(), i == seq_words - 1, 1'b0, '0);
                    rand_words++;
                end
            end
        end

        rx_quiet = 1'b0;
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d sample words (%0d random) over %0d window length writes;",
                 words_sent, rand_words, cfg_writes);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/wpc_pkg.sv
hdl/wpc_cell.sv
hdl/wpc_chain.sv
hdl/window_peak_count_max_core.sv
verif/tb_top.sv
